// ===== hdl/sst_pkg.sv =====
`timescale 1ns / 1ps

package sst_pkg;

   localparam int DEPTH   = 64;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = 7;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 2'd0,
      FN_REMOVE = 2'd1,
      FN_QUERY  = 2'd2,
      FN_NONE   = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      A_IDX  = 2'd0,
      A_PREV = 2'd1,
      A_NEXT = 2'd2
   } addr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SRCH_RD,
      S_SRCH_EV,
      S_DECIDE,
      S_UP_RD,
      S_UP_EV,
      S_DN_RD,
      S_DN_EV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic         load;
      logic         set_status;
      status_type   status;
      logic         save_end;
      logic         save_hit;
      logic         idx_inc;
      logic         idx_dec;
      logic         idx_from_count;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         wr_en;
      logic         wr_key;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     key_ge;
      logic     hit;
      logic     idx_at_count;
      logic     idx_at_pos;
      logic     idx_next_at_count;
      logic     rsp_free;
   } dp_status_type;

endpackage

// ===== hdl/sst_ram.sv =====
`timescale 1ns / 1ps

module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/sst_ctrl.sv =====
`timescale 1ns / 1ps

module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sst_pkg::dp_status_type sts,
   output sst_pkg::cmd_type       cmd
);

   import sst_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.func == FN_NONE || (sts.func == FN_INSERT && sts.full)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            state_in = sts.idx_at_count ? S_DECIDE : S_SRCH_EV;
         end
         S_SRCH_EV: begin
            state_in = sts.key_ge ? S_DECIDE : S_SRCH_RD;
         end
         S_DECIDE: begin
            case (sts.func)
               FN_INSERT: state_in = sts.hit ? S_DONE : S_UP_RD;
               FN_REMOVE: state_in = sts.hit ? S_DN_RD : S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_UP_RD: begin
            state_in = sts.idx_at_pos ? S_DONE : S_UP_EV;
         end
         S_UP_EV: state_in = S_UP_RD;
         S_DN_RD: begin
            state_in = sts.idx_next_at_count ? S_DONE : S_DN_EV;
         end
         S_DN_EV: state_in = S_DN_RD;
         S_DONE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_CHECK: begin
            if (sts.func == FN_NONE) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end else if (sts.func == FN_INSERT && sts.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
            end
         end
         S_SRCH_RD: begin
            if (sts.idx_at_count) begin
               cmd.save_end = 1'b1;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = A_IDX;
            end
         end
         S_SRCH_EV: begin
            if (sts.key_ge) begin
               cmd.save_hit = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DECIDE: begin
            case (sts.func)
               FN_INSERT: begin
                  if (sts.hit) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_MISS;
                  end else begin
                     cmd.idx_from_count = 1'b1;
                  end
               end
               FN_REMOVE: begin
                  if (!sts.hit) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_MISS;
                  end
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = sts.hit ? ST_OK : ST_MISS;
               end
            endcase
         end
         S_UP_RD: begin
            if (sts.idx_at_pos) begin
               // drop the new key into the opened slot
               cmd.wr_en      = 1'b1;
               cmd.wr_key     = 1'b1;
               cmd.cnt_inc    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = A_PREV;
            end
         end
         S_UP_EV: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
         end
         S_DN_RD: begin
            if (sts.idx_next_at_count) begin
               cmd.cnt_dec    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = A_NEXT;
            end
         end
         S_DN_EV: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/sst_dp.sv =====
`timescale 1ns / 1ps

module sst_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sst_pkg::FUNC_W-1:0]   req_func,
   input  logic signed [sst_pkg::DATA_W-1:0] req_value,
   input  logic                         csr_wr_en,
   input  logic [sst_pkg::CNT_W-1:0]    csr_wr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [sst_pkg::STAT_W-1:0]   rsp_status,
   output logic [sst_pkg::CNT_W-1:0]    rsp_count,
   output logic                         rsp_empty_res,
   input  sst_pkg::cmd_type             cmd,
   output sst_pkg::dp_status_type       sts
);

   import sst_pkg::*;

   localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(DEPTH);

   func_type          func_ff, func_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  capacity_ff, capacity_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic [CNT_W-1:0]  idx_m1, idx_p1, limit;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data, wr_data;

   assign idx_m1 = CNT_W'(idx_ff - CNT_W'(1));
   assign idx_p1 = CNT_W'(idx_ff + CNT_W'(1));
   assign limit  = (capacity_ff > DEPTH_C) ? DEPTH_C : capacity_ff;

   always_comb begin
      unique case (cmd.addr_sel)
         A_IDX:   rd_addr = idx_ff[ADDR_W-1:0];
         A_PREV:  rd_addr = idx_m1[ADDR_W-1:0];
         A_NEXT:  rd_addr = idx_p1[ADDR_W-1:0];
         default: rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   assign wr_data = cmd.wr_key ? key_ff : rd_data;

   sst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      hit_in        = hit_ff;
      count_in      = count_ff;
      capacity_in   = capacity_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (csr_wr_en) capacity_in = csr_wr_data;

      if (cmd.load) begin
         func_in = func_type'(req_func);
         // flip the sign so unsigned compare gives signed order
         key_in  = $unsigned(req_value) ^ SIGN_BIT;
         idx_in  = '0;
      end
      if (cmd.idx_inc)        idx_in = idx_p1;
      if (cmd.idx_dec)        idx_in = idx_m1;
      if (cmd.idx_from_count) idx_in = count_ff;
      if (cmd.save_end) begin
         pos_in = idx_ff;
         hit_in = 1'b0;
      end
      if (cmd.save_hit) begin
         pos_in = idx_ff;
         hit_in = (rd_data == key_ff);
      end
      if (cmd.cnt_inc) count_in = CNT_W'(count_ff + CNT_W'(1));
      if (cmd.cnt_dec) count_in = CNT_W'(count_ff - CNT_W'(1));
      if (cmd.set_status) status_in = cmd.status;

      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_count_in  = count_ff;
         rsp_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign sts.func              = func_ff;
   assign sts.full              = (count_ff >= limit);
   assign sts.key_ge            = (rd_data >= key_ff);
   assign sts.hit               = hit_ff;
   assign sts.idx_at_count      = (idx_ff == count_ff);
   assign sts.idx_at_pos        = (idx_ff == pos_ff);
   assign sts.idx_next_at_count = (idx_p1 == count_ff);
   assign sts.rsp_free          = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count above table depth");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> idx_ff <= count_ff)
      else $error("table write beyond live entries");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> count_ff < limit)
      else $error("insert committed into a full set");
`endif

endmodule

// ===== hdl/sorted_set_table_core.sv =====
`timescale 1ns / 1ps

// Sorted set table: holds up to min(capacity, 64) distinct signed 32-bit values in
// ascending order in a single-write, single-read RAM. One request (insert, remove or
// query) is worked at a time and gives one response with status, count and empty flag.
// Each request walks the table one entry at a time (RAM read, then compare or
// write-back): an ascending search up to the first entry not below the value, then for
// insert a shift upward from the top, for remove a shift downward from the hit. An
// insert into a full set or an unused function code skips the search and goes straight
// to the response. A new request is taken while the previous response still waits on
// rsp_ready. capacity is to be written through csr_wr_en / csr_wr_data only while the
// block is idle; the block itself does not enforce this.

module sorted_set_table_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sst_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [sst_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sst_pkg::STAT_W-1:0]        rsp_status,
   output logic [sst_pkg::CNT_W-1:0]         rsp_count,
   output logic                              rsp_empty_res,
   input  logic                              csr_wr_en,
   input  logic [sst_pkg::CNT_W-1:0]         csr_wr_data
);

   import sst_pkg::*;

   cmd_type       cmd;
   dp_status_type sts;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sst_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_value     (req_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule
